// ===== rtl/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types, constants and letter helpers for the Playfair digraph
// encipher block (5x5 square; Q is left out of the fill letters).
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int SqCells   = 25;
  localparam int SqSide    = 5;
  localparam int LetterCnt = 26;
  localparam int CodeW     = 5;

  localparam logic [CodeW-1:0] PadCode   = 5'd23;   // X
  localparam logic [CodeW-1:0] NonLetter = 5'd31;
  localparam logic [CodeW-1:0] QCode     = 5'd16;
  localparam logic [6:0]       AsciiA    = 7'd65;
  localparam logic [7:0]       AsciiSpc  = 8'h20;

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_KEY_END = 2'd1,
    OP_MSG     = 2'd2,
    OP_MSG_END = 2'd3
  } op_e;

  typedef struct packed {
    logic             en;
    logic [CodeW-1:0] slot;
    logic [CodeW-1:0] letter;
  } sq_wr_t;

  typedef struct packed {
    logic [CodeW-1:0] pos_a;
    logic [CodeW-1:0] pos_b;
    logic [CodeW-1:0] cell_a;
    logic [CodeW-1:0] cell_b;
  } sq_rd_t;

  function automatic logic [CodeW-1:0] sym_code(input logic [7:0] b);
    logic [7:0] d;
    d = 8'(b - 8'h41);
    if (b >= 8'h41 && b <= 8'h5A) return d[CodeW-1:0];
    d = 8'(b - 8'h61);
    if (b >= 8'h61 && b <= 8'h7A) return d[CodeW-1:0];
    return NonLetter;
  endfunction

  // alphabet order with Q left out
  function automatic logic [CodeW-1:0] fill_letter(input logic [CodeW-1:0] idx);
    return (idx < QCode) ? idx : CodeW'(idx + 5'd1);
  endfunction

  function automatic logic [2:0] row_of(input logic [CodeW-1:0] k);
    if (k < CodeW'(SqSide))     return 3'd0;
    if (k < CodeW'(2 * SqSide)) return 3'd1;
    if (k < CodeW'(3 * SqSide)) return 3'd2;
    if (k < CodeW'(4 * SqSide)) return 3'd3;
    return 3'd4;
  endfunction

endpackage

// ===== rtl/pfde_store.sv =====
// ----------------------------------------------------------------------------
// pfde_store
// Square memory (cell -> letter) and position memory (letter -> cell).
// One write port each, two registered read ports each.
// ----------------------------------------------------------------------------
module pfde_store (
  input  logic                        clk_i,
  input  pfde_pkg::sq_wr_t            wr_i,
  input  pfde_pkg::sq_rd_t            rd_i,
  output logic [pfde_pkg::CodeW-1:0]  pos_a_o,
  output logic [pfde_pkg::CodeW-1:0]  pos_b_o,
  output logic [pfde_pkg::CodeW-1:0]  let_a_o,
  output logic [pfde_pkg::CodeW-1:0]  let_b_o
);

  logic [pfde_pkg::CodeW-1:0] sq_mem  [pfde_pkg::SqCells];
  logic [pfde_pkg::CodeW-1:0] pos_mem [pfde_pkg::LetterCnt];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      sq_mem[wr_i.slot]    <= wr_i.letter;
      pos_mem[wr_i.letter] <= wr_i.slot;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_a_o <= pos_mem[rd_i.pos_a];
    pos_b_o <= pos_mem[rd_i.pos_b];
    let_a_o <= sq_mem[rd_i.cell_a];
    let_b_o <= sq_mem[rd_i.cell_b];
  end

endmodule

// ===== rtl/playfair_digraph_encipher_top.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encipher_top
// Playfair digraph encipher: builds the square from key bytes, pairs message
// letters and emits enciphered pairs.
//
// channel  dir  tdata                      tuser
// s_axis   in   [7:0] char_in              [1:0] operation
// m_axis   out  [6:0] first, [13:7] second [0] bad_symbol
//
// Key byte: written to the memories in the same cycle it is accepted.
// End of key: one fill letter per cycle through the memories, present ones skipped.
// Pair result: accept, position read, square read, output load, in that order,
// set by the two dependent memory reads; a flagged pair goes straight to the load.
// Output register holds one word; a pair waits in the load state while it
// is occupied. Reset clears control state, present bits and fill count.
// ----------------------------------------------------------------------------
module playfair_digraph_encipher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] first_letter, [13:7] second_letter
  output logic        m_axis_tuser    // [0] bad_symbol
);

  localparam int CW = pfde_pkg::CodeW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_RDPOS = 3'd2;
  localparam logic [2:0] ST_RDSQ  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [pfde_pkg::LetterCnt-1:0] present_q, present_d;
  logic [CW-1:0] pend_q, pend_d;
  logic        pend_vld_q, pend_vld_d;
  logic [CW-1:0] pa_q, pa_d, pb_q, pb_d;
  logic [6:0]  res_first_q, res_first_d, res_second_q, res_second_d;
  logic        res_bad_q, res_bad_d;
  logic        out_vld_q, out_vld_d;
  logic [6:0]  out_first_q, out_second_q;
  logic        out_bad_q;
  logic        out_load;

  logic [31:0] present_ext;
  logic        sq_full;
  logic        in_fire;
  pfde_pkg::op_e op;
  logic [CW-1:0] code, place_code;
  logic        place_en;

  pfde_pkg::sq_wr_t wr;
  pfde_pkg::sq_rd_t rd;
  logic [CW-1:0] k0, k1, let_a, let_b;

  logic [2:0]  r0, r1, c0, c1;
  logic [CW-1:0] base0, base1, o0, o1;

  pfde_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .pos_a_o (k0),
    .pos_b_o (k1),
    .let_a_o (let_a),
    .let_b_o (let_b)
  );

  assign present_ext = {{(32 - pfde_pkg::LetterCnt){1'b0}}, present_q};
  assign sq_full     = (fill_q == CW'(pfde_pkg::SqCells));
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign op          = pfde_pkg::op_e'(s_axis_tuser);
  assign code        = pfde_pkg::sym_code(s_axis_tdata);

  // cell arithmetic on the positions read back
  always_comb begin
    r0    = pfde_pkg::row_of(k0);
    r1    = pfde_pkg::row_of(k1);
    base0 = CW'({r0, 2'b00}) + CW'(r0);
    base1 = CW'({r1, 2'b00}) + CW'(r1);
    c0    = 3'(k0 - base0);
    c1    = 3'(k1 - base1);
    if (r0 == r1) begin
      o0 = base0 + ((c0 == 3'(pfde_pkg::SqSide - 1)) ? '0 : CW'(c0 + 3'd1));
      o1 = base1 + ((c1 == 3'(pfde_pkg::SqSide - 1)) ? '0 : CW'(c1 + 3'd1));
    end else if (c0 == c1) begin
      o0 = (k0 >= CW'(pfde_pkg::SqCells - pfde_pkg::SqSide)) ?
           CW'(k0 - CW'(pfde_pkg::SqCells - pfde_pkg::SqSide)) :
           CW'(k0 + CW'(pfde_pkg::SqSide));
      o1 = (k1 >= CW'(pfde_pkg::SqCells - pfde_pkg::SqSide)) ?
           CW'(k1 - CW'(pfde_pkg::SqCells - pfde_pkg::SqSide)) :
           CW'(k1 + CW'(pfde_pkg::SqSide));
    end else begin
      o0 = base0 + CW'(c1);
      o1 = base1 + CW'(c0);
    end
  end

  assign rd.pos_a  = pa_d;
  assign rd.pos_b  = pb_d;
  assign rd.cell_a = o0;
  assign rd.cell_b = o1;

  always_comb begin
    place_en   = 1'b0;
    place_code = code;
    if (state_q == ST_FILL) begin
      place_code = pfde_pkg::fill_letter(idx_q);
      place_en   = 1'b1;
    end else if (in_fire && op == pfde_pkg::OP_KEY) begin
      place_en   = (code < CW'(pfde_pkg::LetterCnt));
    end
    place_en = place_en && !sq_full && !present_ext[place_code];
  end

  assign wr.en     = place_en;
  assign wr.slot   = fill_q;
  assign wr.letter = place_code;

  always_comb begin
    logic          start;
    logic [CW-1:0] a, b;
    start        = 1'b0;
    a            = pend_q;
    b            = pfde_pkg::PadCode;
    state_d      = state_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    present_d    = present_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    pa_d         = pa_q;
    pb_d         = pb_q;
    res_first_d  = res_first_q;
    res_second_d = res_second_q;
    res_bad_d    = res_bad_q;
    out_load     = 1'b0;

    if (place_en) begin
      fill_d                = CW'(fill_q + 5'd1);
      present_d[place_code] = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op)
            pfde_pkg::OP_KEY: ;
            pfde_pkg::OP_KEY_END: begin
              idx_d   = '0;
              state_d = ST_FILL;
            end
            pfde_pkg::OP_MSG: begin
              if (s_axis_tdata != pfde_pkg::AsciiSpc) begin
                if (!pend_vld_q) begin
                  pend_d     = code;
                  pend_vld_d = 1'b1;
                end else begin
                  start = 1'b1;
                  if (code != pend_q) begin
                    b          = code;
                    pend_vld_d = 1'b0;
                  end
                end
              end
            end
            pfde_pkg::OP_MSG_END: begin
              if (pend_vld_q) begin
                start      = 1'b1;
                pend_vld_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
        if (start) begin
          pa_d = a;
          pb_d = b;
          if (sq_full && present_ext[a] && present_ext[b]) begin
            state_d = ST_RDPOS;
          end else begin
            res_first_d  = '0;
            res_second_d = '0;
            res_bad_d    = 1'b1;
            state_d      = ST_EMIT;
          end
        end
      end
      ST_FILL: begin
        idx_d = CW'(idx_q + 5'd1);
        if (idx_q == CW'(pfde_pkg::SqCells - 1) || sq_full) begin
          state_d = ST_IDLE;
        end
      end
      ST_RDPOS: state_d = ST_RDSQ;
      ST_RDSQ: begin
        res_first_d  = 7'(let_a) + pfde_pkg::AsciiA;
        res_second_d = 7'(let_b) + pfde_pkg::AsciiA;
        res_bad_d    = 1'b0;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_vld_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      idx_q      <= '0;
      present_q  <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      idx_q      <= idx_d;
      present_q  <= present_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q         <= pa_d;
    pb_q         <= pb_d;
    res_first_q  <= res_first_d;
    res_second_q <= res_second_d;
    res_bad_q    <= res_bad_d;
    if (out_load) begin
      out_first_q  <= res_first_q;
      out_second_q <= res_second_q;
      out_bad_q    <= res_bad_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_second_q, out_first_q};
  assign m_axis_tuser  = out_bad_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(pfde_pkg::SqCells))
    else $error("fill count beyond square size");

  a_fill_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && state_d == ST_IDLE) |=> fill_q == CW'(pfde_pkg::SqCells))
    else $error("square not full after end of key");

  a_pos_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RDPOS |-> (present_ext[pa_q] && present_ext[pb_q] && sq_full))
    else $error("position read of a letter not in the square");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || m_axis_tready))
    else $error("output word overwritten before taken");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == 16'd0)
    else $error("flagged pair carries letters");
`endif

endmodule
